/* hdl/char_lcd_cursor_terminal_macros.svh */
// Assertion helpers for the character LCD terminal.
`ifndef CHAR_LCD_CURSOR_TERMINAL_MACROS_SVH
`define CHAR_LCD_CURSOR_TERMINAL_MACROS_SVH

// Same-cycle implication.
`define CLT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication.
`define CLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* hdl/clt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

   // control characters
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam logic [7:0] POS_CMD     = 8'h80;
   localparam logic [7:0] LINE_STRIDE = 8'h40;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // register map (index = paddr[2])
   localparam int  CSR_ADDR_W       = 3;
   localparam logic REG_COLUMN_COUNT = 1'b0;
   localparam logic REG_LINE_COUNT   = 1'b1;

   localparam logic [5:0] COLUMN_MIN   = 6'd8;
   localparam logic [5:0] COLUMN_RESET = 6'd16;
   localparam logic [1:0] LINE_MIN     = 2'd1;
   localparam logic [1:0] LINE_RESET   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_RESTORE
   } state_type;

   typedef struct packed {
      logic [5:0] last_column;
      logic [1:0] line_count;
      logic       update;
   } cfg_type;

   typedef struct packed {
      logic [5:0] a;
      logic       dec;
      logic [5:0] limit;
   } alu_req_type;

   typedef struct packed {
      logic [5:0] sum;
      logic       at_limit;
      logic       past_limit;
   } alu_rsp_type;

   function automatic logic [7:0] pos_cmd(input logic line, input logic [5:0] column);
      pos_cmd = POS_CMD + (line ? LINE_STRIDE : 8'h00) + {2'b00, column};
   endfunction

endpackage

`default_nettype wire

/* hdl/clt_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module clt_csr #(
   parameter int MAX_COLUMNS = 40,
   parameter int MAX_LINES   = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [clt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output clt_pkg::cfg_type                      cfg
);

   localparam logic [5:0] COL_MAX  = 6'(MAX_COLUMNS);
   localparam logic [1:0] LINE_MAX = 2'(MAX_LINES);

   logic [5:0] column_count_ff, column_count_in;
   logic [5:0] last_column_ff, last_column_in;
   logic [1:0] line_count_ff, line_count_in;
   logic       update_ff, update_in;
   logic       wr;
   logic       index;
   logic [5:0] col_sat;
   logic [1:0] line_sat;

   assign wr    = psel & penable & pwrite;
   assign index = paddr[2];

   always_comb begin
      col_sat = pwdata[5:0];
      if (col_sat < clt_pkg::COLUMN_MIN) begin
         col_sat = clt_pkg::COLUMN_MIN;
      end else if (col_sat > COL_MAX) begin
         col_sat = COL_MAX;
      end
      line_sat = pwdata[1:0];
      if (line_sat < clt_pkg::LINE_MIN) begin
         line_sat = clt_pkg::LINE_MIN;
      end else if (line_sat > LINE_MAX) begin
         line_sat = LINE_MAX;
      end
   end

   always_comb begin
      column_count_in = column_count_ff;
      last_column_in  = last_column_ff;
      line_count_in   = line_count_ff;
      update_in       = wr;
      if (wr) begin
         case (index)
            clt_pkg::REG_COLUMN_COUNT: begin
               column_count_in = col_sat;
               last_column_in  = col_sat - 6'd1;
            end
            clt_pkg::REG_LINE_COUNT: begin
               line_count_in = line_sat;
            end
            default: begin
               update_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= clt_pkg::COLUMN_RESET;
         last_column_ff  <= clt_pkg::COLUMN_RESET - 6'd1;
         line_count_ff   <= clt_pkg::LINE_RESET;
         update_ff       <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         last_column_ff  <= last_column_in;
         line_count_ff   <= line_count_in;
         update_ff       <= update_in;
      end
   end

   always_comb begin
      case (index)
         clt_pkg::REG_COLUMN_COUNT: prdata = {26'd0, column_count_ff};
         clt_pkg::REG_LINE_COUNT:   prdata = {30'd0, line_count_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   assign cfg.last_column = last_column_ff;
   assign cfg.line_count  = line_count_ff;
   assign cfg.update      = update_ff;

endmodule

`default_nettype wire

/* hdl/clt_col_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// column step and compare against the last column
module clt_col_alu (
   input  wire clt_pkg::alu_req_type req,
   output clt_pkg::alu_rsp_type      rsp
);

   assign rsp.sum        = req.dec ? (req.a - 6'd1) : (req.a + 6'd1);
   assign rsp.at_limit   = (req.a == req.limit);
   assign rsp.past_limit = (req.a >= req.limit);

endmodule

`default_nettype wire

/* hdl/char_lcd_cursor_terminal.sv */
`timescale 1ns / 1ps
`default_nettype none

// Character LCD cursor terminal. Each request carries one character byte; the block
// tracks the cursor (line, column) and produces the byte transfers a character LCD
// controller expects, each tagged command (reg_select 0) or data (reg_select 1), with
// last_transfer set on the final transfer of a request. Backspace, form feed, line
// feed and carriage return move the cursor with one position command (0x80 + line*0x40
// + column); backspace and return at column 0 send nothing. Vertical tab sends spaces
// up to the end of the line and then a command restoring the cursor. Other bytes are
// written as data and advance the cursor, except at the last column, where they are
// dropped silently. Some requests therefore produce no response at all. A request is
// taken in idle and decoded in the next cycle; no new one is taken until idle again.
// Clear-to-eol walks the line in the fill state with a single column step/compare unit,
// one space per cycle unless the response side stalls (a stall holds any emitting
// state), then restores the cursor from the restore state. Registers (APB, 32-bit):
// 0x0 column_count (saturates to 8..MAX_COLUMNS, reset 16), 0x4 line_count (saturates
// to 1..MAX_LINES, reset 2); a write that leaves the cursor out of range clamps it via
// the update flag register. Write registers only while the block is idle.
module char_lcd_cursor_terminal #(
   parameter int MAX_COLUMNS = 40,
   parameter int MAX_LINES   = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_char_code,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_reg_select,
   output logic      [7:0]                     rsp_lcd_byte,
   output logic                                rsp_last_transfer,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [clt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   clt_pkg::cfg_type     cfg;
   clt_pkg::alu_req_type alu_req;
   clt_pkg::alu_rsp_type alu_rsp;
   clt_pkg::state_type   state_ff, state_in;

   logic [7:0] char_ff, char_in;
   logic       line_ff, line_in;      // cursor line
   logic [5:0] col_ff, col_in;        // cursor column
   logic [5:0] cnt_ff, cnt_in;        // space fill position

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_rs_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic       emit;
   logic       emit_rs;
   logic [7:0] emit_byte;
   logic       emit_last;
   logic       out_free;
   logic       fire;
   logic       next_line;

   assign csr_pready = 1'b1;

   clt_csr #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_LINES   (MAX_LINES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   clt_col_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = emit && out_free;
   // line feed wraps past the last line
   assign next_line = !line_ff && (cfg.line_count > 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clt_pkg::ST_IDLE;
         line_ff  <= 1'b0;
         col_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      emit          = 1'b0;
      emit_rs       = clt_pkg::RS_COMMAND;
      emit_byte     = clt_pkg::pos_cmd(line_ff, col_ff);
      emit_last     = 1'b1;
      alu_req.a     = col_ff;
      alu_req.dec   = 1'b0;
      alu_req.limit = cfg.last_column;

      case (state_ff)
         clt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               char_in  = req_char_code;
               state_in = clt_pkg::ST_DECODE;
            end
            // clamp after a register write (the user must write only while idle; the block does not enforce it)
            if (cfg.update) begin
               if (alu_rsp.past_limit && !alu_rsp.at_limit) begin
                  col_in = cfg.last_column;
               end
               if (cfg.line_count < 2'd2) begin
                  line_in = 1'b0;
               end
            end
         end

         clt_pkg::ST_DECODE: begin
            case (char_ff)
               clt_pkg::CHAR_BS: begin
                  alu_req.dec = 1'b1;
                  if (col_ff == 6'd0) begin
                     state_in = clt_pkg::ST_IDLE;
                  end else begin
                     emit      = 1'b1;
                     emit_byte = clt_pkg::pos_cmd(line_ff, alu_rsp.sum);
                     if (out_free) begin
                        col_in   = alu_rsp.sum;
                        state_in = clt_pkg::ST_IDLE;
                     end
                  end
               end
               clt_pkg::CHAR_FF: begin
                  emit      = 1'b1;
                  emit_byte = clt_pkg::POS_CMD;
                  if (out_free) begin
                     line_in  = 1'b0;
                     col_in   = 6'd0;
                     state_in = clt_pkg::ST_IDLE;
                  end
               end
               clt_pkg::CHAR_LF: begin
                  emit      = 1'b1;
                  emit_byte = clt_pkg::pos_cmd(next_line, 6'd0);
                  if (out_free) begin
                     line_in  = next_line;
                     col_in   = 6'd0;
                     state_in = clt_pkg::ST_IDLE;
                  end
               end
               clt_pkg::CHAR_CR: begin
                  if (col_ff == 6'd0) begin
                     state_in = clt_pkg::ST_IDLE;
                  end else begin
                     emit      = 1'b1;
                     emit_byte = clt_pkg::pos_cmd(line_ff, 6'd0);
                     if (out_free) begin
                        col_in   = 6'd0;
                        state_in = clt_pkg::ST_IDLE;
                     end
                  end
               end
               clt_pkg::CHAR_VT: begin
                  if (alu_rsp.at_limit) begin
                     state_in = clt_pkg::ST_IDLE;
                  end else begin
                     cnt_in   = col_ff;
                     state_in = clt_pkg::ST_FILL;
                  end
               end
               default: begin
                  // any other byte: written as data, dropped at the last column
                  if (alu_rsp.past_limit) begin
                     state_in = clt_pkg::ST_IDLE;
                  end else begin
                     emit      = 1'b1;
                     emit_rs   = clt_pkg::RS_DATA;
                     emit_byte = char_ff;
                     if (out_free) begin
                        col_in   = alu_rsp.sum;
                        state_in = clt_pkg::ST_IDLE;
                     end
                  end
               end
            endcase
         end

         clt_pkg::ST_FILL: begin
            alu_req.a = cnt_ff;
            emit      = 1'b1;
            emit_rs   = clt_pkg::RS_DATA;
            emit_byte = clt_pkg::SPACE_CHAR;
            emit_last = 1'b0;
            if (out_free) begin
               if (alu_rsp.at_limit) begin
                  state_in = clt_pkg::ST_RESTORE;
               end else begin
                  cnt_in = alu_rsp.sum;
               end
            end
         end

         clt_pkg::ST_RESTORE: begin
            emit = 1'b1;
            if (out_free) begin
               state_in = clt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = clt_pkg::ST_IDLE;
         end
      endcase
   end

   // response register: refilled in the cycle it is taken
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_rs_ff   <= emit_rs;
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reg_select    = rsp_rs_ff;
   assign rsp_lcd_byte      = rsp_byte_ff;
   assign rsp_last_transfer = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/clt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_cursor_terminal_macros.svh"

module clt_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [7:0]                     req_char_code,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_reg_select,
   input wire logic [7:0]                     rsp_lcd_byte,
   input wire logic                           rsp_last_transfer,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic [clt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [31:0]                    csr_pwdata,
   input wire logic [31:0]                    csr_prdata,
   input wire logic                           csr_pready
);

   logic [9:0] rsp_word;

   assign rsp_word = {rsp_reg_select, rsp_lcd_byte, rsp_last_transfer};

   // stalled response holds
   `CLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // one request at a time
   `CLT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // commands are always cursor positions
   `CLT_ASSERT_IMPLY(a_cmd_is_position, clock, reset, rsp_valid && !rsp_reg_select, rsp_lcd_byte[7])

   // a command always closes its request
   `CLT_ASSERT_IMPLY(a_cmd_is_last, clock, reset, rsp_valid && !rsp_reg_select, rsp_last_transfer)

endmodule

bind char_lcd_cursor_terminal clt_checker u_clt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_char_code     (req_char_code),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_reg_select    (rsp_reg_select),
   .rsp_lcd_byte      (rsp_lcd_byte),
   .rsp_last_transfer (rsp_last_transfer),
   .csr_psel          (csr_psel),
   .csr_penable       (csr_penable),
   .csr_pwrite        (csr_pwrite),
   .csr_paddr         (csr_paddr),
   .csr_pwdata        (csr_pwdata),
   .csr_prdata        (csr_prdata),
   .csr_pready        (csr_pready)
);

`default_nettype wire
